// ===== sv/bnrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Bond neighbor relation table package
// Field widths, action and relation codes, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bnrt_pkg;

    localparam int ACT_W         = 2;
    localparam int ATOM_W        = 6;
    localparam int REL_W         = 2;
    localparam int MAX_ATOMS_DEF = 64;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BOND  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [REL_W-1:0] REL_BONDED = 2'd0;
    localparam logic [REL_W-1:0] REL_SHARED = 2'd1;
    localparam logic [REL_W-1:0] REL_NONE   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // input beat accepted: latch indexes and read both rows
        logic clear;     // drop every row of the table
        logic wr_a;      // write back the row of the first atom
        logic wr_b;      // write back the row of the second atom
        logic load_res;  // load the relation into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bond_ok;   // both indexes in range and distinct
    } t_stat;

endpackage

// ===== sv/bnrt_in_if.sv =====
// ----------------------------------------------------------------------------
// Bond neighbor relation table input channel
// Valid/ready channel that carries one action with its atom pair per beat.
// ----------------------------------------------------------------------------
interface bnrt_in_if import bnrt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ATOM_W-1:0] atom_a;
    logic [ATOM_W-1:0] atom_b;

    modport source (output valid, output action, output atom_a, output atom_b,
                    input ready);
    modport sink   (input valid, input action, input atom_a, input atom_b,
                    output ready);

endinterface

// ===== sv/bnrt_out_if.sv =====
// ----------------------------------------------------------------------------
// Bond neighbor relation table output channel
// Valid/ready channel that carries one relation code per beat.
// ----------------------------------------------------------------------------
interface bnrt_out_if import bnrt_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [REL_W-1:0] relation;

    modport source (output valid, output relation, input ready);
    modport sink   (input valid, input relation, output ready);

endinterface

// ===== sv/bnrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bond neighbor relation table controller
// Sequences each accepted beat: clear at once, a bond as two row writes or
// none for a bad pair, a query as a compare that loads the output register.
// ----------------------------------------------------------------------------
module bnrt_ctrl import bnrt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [ACT_W-1:0] i_action,
    input  logic             i_out_ready,
    input  t_stat            i_stat,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output t_cmd             o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BOND_A,
        S_BOND_B,
        S_QUERY
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    // The output register can take a new result when empty or drained now.
    assign slot_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_action)
                        ACT_CLEAR: o_cmd.clear = 1'b1;
                        ACT_BOND:  n_state = S_BOND_A;
                        ACT_QUERY: n_state = S_QUERY;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_BOND_A: begin
                if (i_stat.bond_ok) begin
                    o_cmd.wr_a = 1'b1;
                    n_state    = S_BOND_B;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BOND_B: begin
                o_cmd.wr_b = 1'b1;
                n_state    = S_IDLE;
            end
            S_QUERY: begin
                if (slot_free) begin
                    o_cmd.load_res = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/bnrt_datapath.sv =====
// ----------------------------------------------------------------------------
// Bond neighbor relation table datapath
// Adjacency row memory with per-row valid bits, registered row reads,
// the row write-back path and the relation compare.
// ----------------------------------------------------------------------------
module bnrt_datapath import bnrt_pkg::*; #(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [ATOM_W-1:0] i_atom_a,
    input  logic [ATOM_W-1:0] i_atom_b,
    output t_stat             o_stat,
    output logic [REL_W-1:0]  o_relation
);

    localparam int AW = $clog2(MAX_ATOMS);
    localparam int IW = (AW > ATOM_W) ? AW : ATOM_W;
    localparam logic [MAX_ATOMS-1:0] ROW_ONE = MAX_ATOMS'(1);

    logic [MAX_ATOMS-1:0] mem [MAX_ATOMS];
    logic [MAX_ATOMS-1:0] r_row_valid;

    logic [IW-1:0]        ext_a, ext_b;
    logic [AW-1:0]        addr_a, addr_b;
    logic                 ok_a, ok_b;

    logic [MAX_ATOMS-1:0] r_row_a, r_row_b;
    logic                 r_vld_a, r_vld_b;
    logic [AW-1:0]        r_addr_a, r_addr_b;
    logic                 r_ok_a, r_ok_b;
    logic [REL_W-1:0]     r_relation;

    logic [MAX_ATOMS-1:0] eff_a, eff_b;
    logic                 same;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [MAX_ATOMS-1:0] wr_data;
    logic [REL_W-1:0]     n_relation;

    assign ext_a  = IW'(i_atom_a);
    assign ext_b  = IW'(i_atom_b);
    assign addr_a = ext_a[AW-1:0];
    assign addr_b = ext_b[AW-1:0];
    assign ok_a   = {1'b0, ext_a} < (IW+1)'(MAX_ATOMS);
    assign ok_b   = {1'b0, ext_b} < (IW+1)'(MAX_ATOMS);

    // A row that was never written since the last clear reads as empty.
    assign eff_a = r_vld_a ? r_row_a : '0;
    assign eff_b = r_vld_b ? r_row_b : '0;
    assign same  = (r_addr_a == r_addr_b);

    assign o_stat.bond_ok = r_ok_a && r_ok_b && !same;

    assign wr_en   = i_cmd.wr_a || i_cmd.wr_b;
    assign wr_addr = i_cmd.wr_a ? r_addr_a : r_addr_b;
    assign wr_data = i_cmd.wr_a ? (eff_a | (ROW_ONE << r_addr_b))
                                : (eff_b | (ROW_ONE << r_addr_a));

    // A direct bond wins over a shared neighbor.
    always_comb begin
        if (!r_ok_a || !r_ok_b || same) begin
            n_relation = REL_NONE;
        end else if (eff_a[r_addr_b]) begin
            n_relation = REL_BONDED;
        end else if (|(eff_a & eff_b)) begin
            n_relation = REL_SHARED;
        end else begin
            n_relation = REL_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.capture) begin
            r_row_a  <= mem[addr_a];
            r_row_b  <= mem[addr_b];
            r_vld_a  <= r_row_valid[addr_a];
            r_vld_b  <= r_row_valid[addr_b];
            r_addr_a <= addr_a;
            r_addr_b <= addr_b;
            r_ok_a   <= ok_a;
            r_ok_b   <= ok_b;
        end
        if (i_cmd.load_res) begin
            r_relation <= n_relation;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_row_valid <= '0;
        end else if (wr_en) begin
            r_row_valid[wr_addr] <= 1'b1;
        end
    end

    assign o_relation = r_relation;

endmodule

// ===== sv/bond_neighbor_relation_table.sv =====
// ----------------------------------------------------------------------------
// Bond neighbor relation table
// Symmetric atom adjacency bitmap answering 1-2 / 1-3 relation queries.
// ----------------------------------------------------------------------------
// The block keeps one bitmap row per atom and takes one beat at a time on its
// input channel. A clear beat needs no further state: each row has a valid
// bit, and dropping all of them at once makes the whole table read as empty.
// An add-bond beat first reads both rows from the adjacency memory into
// registers, then writes back one row after the other, since the memory has
// a single write port. A bond whose atoms are equal or out of range writes
// nothing. A query beat reads both rows, then a compare state tests them
// (bit test for a direct bond, wide AND for a shared neighbor) and loads the
// output register once it is free. The query result waits in that register
// until the sink takes it; the next input beat may be accepted meanwhile,
// and a following query stalls only while the register is full.
// Relation codes: 0 bonded, 1 shared neighbor, 3 otherwise or for the same
// atom twice. A direct bond always wins over a shared neighbor. No reset pass
// is needed; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module bond_neighbor_relation_table import bnrt_pkg::*; #(
    parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bnrt_in_if.sink     i_item,
    bnrt_out_if.source  o_result
);

    t_cmd  cmd;
    t_stat stat;

    // The controller owns every handshake; the datapath only holds data.
    bnrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_action    (i_item.action),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (cmd)
    );

    // Rows are read on the accepted beat, so the atom fields go straight in.
    bnrt_datapath #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_atom_a   (i_item.atom_a),
        .i_atom_b   (i_item.atom_b),
        .o_stat     (stat),
        .o_relation (o_result.relation)
    );

    // The first row write of a bond is always followed by the second one.
    a_bond_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_a |=> cmd.wr_b)
        else $error("bond write-back of first row not followed by second row");

    // No new beat is taken while a bond is still being written back.
    a_no_accept_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_a || cmd.wr_b) |-> !i_item.ready)
        else $error("input ready during a row write-back");

    // A result never overwrites one that the sink has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_res |-> (!o_result.valid || o_result.ready))
        else $error("result register loaded while still full");

    // A query taken with an empty output register loads its result in the next cycle.
    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.capture && i_item.action == ACT_QUERY && !o_result.valid)
        |=> cmd.load_res)
        else $error("query result not loaded one cycle after capture");

endmodule

// ===== tb/sv/bnrt_relation_sb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bond neighbor relation table scoreboard
// Keeps its own adjacency bitmap, predicts the relation of every query beat
// and compares the relations that leave the block in order.
// ----------------------------------------------------------------------------
package bnrt_relation_sb_pkg;

    import bnrt_pkg::*;

    // Action code 3 has no meaning; the block must ignore it.
    localparam logic [ACT_W-1:0] ACT_UNUSED   = 2'd3;
    localparam int               REPORT_LIMIT = 10;

    class relation_scoreboard;

        logic [MAX_ATOMS_DEF-1:0] bond_rows [MAX_ATOMS_DEF];
        logic [REL_W-1:0]         pending_relations [$];
        int mismatches;
        int matched;
        int beats;
        int clears;
        int bonds;
        int queries;
        int unused;
        int rel_count [4];

        function new();
            clear_rows();
            mismatches = 0;
            matched    = 0;
            beats      = 0;
            clears     = 0;
            bonds      = 0;
            queries    = 0;
            unused     = 0;
            foreach (rel_count[i]) rel_count[i] = 0;
        endfunction

        function void clear_rows();
            foreach (bond_rows[r]) bond_rows[r] = '0;
        endfunction

        // A direct bond wins over a shared neighbor, so three-membered rings
        // still answer bonded.
        function logic [REL_W-1:0] relation_of(int a, int b);
            if (a >= MAX_ATOMS_DEF || b >= MAX_ATOMS_DEF || a == b) return REL_NONE;
            if (bond_rows[a][b]) return REL_BONDED;
            if ((bond_rows[a] & bond_rows[b]) != '0) return REL_SHARED;
            return REL_NONE;
        endfunction

        function void note_beat(logic [ACT_W-1:0] act, logic [ATOM_W-1:0] atom_a,
                                logic [ATOM_W-1:0] atom_b);
            int               a;
            int               b;
            logic [REL_W-1:0] rel;
            a = atom_a;
            b = atom_b;
            beats++;
            case (act)
                ACT_CLEAR: begin
                    clears++;
                    clear_rows();
                end
                ACT_BOND: begin
                    bonds++;
                    if (a < MAX_ATOMS_DEF && b < MAX_ATOMS_DEF && a != b) begin
                        bond_rows[a][b] = 1'b1;
                        bond_rows[b][a] = 1'b1;
                    end
                end
                ACT_QUERY: begin
                    queries++;
                    rel = relation_of(a, b);
                    rel_count[rel]++;
                    pending_relations = {pending_relations, rel};
                end
                default: begin
                    unused++;
                end
            endcase
        endfunction

        function void check_relation(logic [REL_W-1:0] got);
            logic [REL_W-1:0] want;
            if (pending_relations.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: relation %0d arrived with no query outstanding", got);
                return;
            end
            want = pending_relations.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: relation beat %0d: expected %0d, got %0d",
                             matched + mismatches, want, got);
            end else begin
                matched++;
            end
        endfunction

        function int outstanding();
            return pending_relations.size();
        endfunction

        // Queries still waiting at the end count as failures too.
        function int finish_check();
            if (pending_relations.size() != 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("ERROR: %0d query results never arrived",
                             pending_relations.size());
                mismatches += pending_relations.size();
            end
            return mismatches;
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_bond_neighbor_relation_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bond neighbor relation table testbench
// Drives clear, add-bond, query and unused beats into the table and checks
// every relation against a bitmap predictor, under random idling on both
// channels, a long output stall and small random molecules.
// ----------------------------------------------------------------------------
module tb_bond_neighbor_relation_table;

    import bnrt_pkg::*;
    import bnrt_relation_sb_pkg::*;

    // Rough number of input beats; the random part stops once it is reached.
    localparam int ITEM_TARGET   = 900;
    // Length of the long output stall, in clock cycles.
    localparam int HOLD_CYCLES   = 120;
    // Cycles allowed after the last result for any late, stray beat.
    localparam int SETTLE_CYCLES = 8;
    // Far beyond the slowest correct run.
    localparam int WATCHDOG_NS   = 1_000_000;

    logic i_clk         = 1'b0;
    logic i_rst_n;
    logic sink_hold     = 1'b0;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    int   items_sent    = 0;
    int   failures;

    bnrt_in_if  item_if ();
    bnrt_out_if result_if ();

    relation_scoreboard sb;

    bond_neighbor_relation_table DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(WATCHDOG_NS);
        $display("Timeout: the run did not finish in time.");
        $display("CHECK FAILED");
        $finish;
    end

    // Result side. Every accepted relation beat goes to the scoreboard; ready
    // is then redrawn for the next cycle, or held low while a long stall is
    // requested. Values are sampled before the edge updates anything.
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready)
                sb.check_relation(result_if.relation);
            if (!i_rst_n || sink_hold)
                result_if.ready <= 1'b0;
            else
                result_if.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
        end
    end

    // Offers one beat, after a random number of idle cycles, and returns at
    // the edge where it is accepted. Valid stays high on return, so a beat
    // that follows at once goes out without a bubble.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [ATOM_W-1:0] a,
                             input logic [ATOM_W-1:0] b);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid  <= 1'b1;
        item_if.action <= act;
        item_if.atom_a <= a;
        item_if.atom_b <= b;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        sb.note_beat(act, a, b);
        items_sent++;
    endtask

    // Stops offering beats and waits until every query has been answered.
    task automatic drain_results();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Malformed or stray beats: the unused action code, self bonds, queries of
    // an atom with itself, and bonds or queries anywhere in the index range.
    task automatic send_noise();
        logic [ATOM_W-1:0] a;
        logic [ATOM_W-1:0] b;
        a = ATOM_W'($urandom);
        b = ATOM_W'($urandom);
        case ($urandom_range(4, 0))
            0:       send_item(ACT_UNUSED, a, b);
            1:       send_item(ACT_BOND, a, a);
            2:       send_item(ACT_QUERY, a, b);
            3:       send_item(ACT_QUERY, a, a);
            default: send_item(ACT_BOND, a, b);
        endcase
    endtask

    // One small molecule: a clear, random bonds among a window of a few
    // neighboring indexes (it may wrap past 63 to 0), then queries among the
    // same atoms. Small windows make shared neighbors and rings of three
    // common. About one beat in ten is noise.
    task automatic send_molecule();
        int                span;
        int                bond_total;
        int                query_total;
        logic [ATOM_W-1:0] base;
        logic [ATOM_W-1:0] a;
        logic [ATOM_W-1:0] b;
        span        = $urandom_range(12, 3);
        base        = ATOM_W'($urandom);
        bond_total  = $urandom_range(2 * span, 2);
        query_total = $urandom_range(3 * span, span);
        send_item(ACT_CLEAR, ATOM_W'($urandom), ATOM_W'($urandom));
        repeat (bond_total) begin
            a = base + ATOM_W'($urandom_range(span - 1, 0));
            b = base + ATOM_W'($urandom_range(span - 1, 0));
            if ($urandom_range(9, 0) == 0) send_noise();
            else send_item(ACT_BOND, a, b);
        end
        repeat (query_total) begin
            a = base + ATOM_W'($urandom_range(span - 1, 0));
            b = base + ATOM_W'($urandom_range(span - 1, 0));
            if ($urandom_range(9, 0) == 0) send_noise();
            else send_item(ACT_QUERY, a, b);
        end
    endtask

    initial begin
        item_if.valid  = 1'b0;
        item_if.action = ACT_CLEAR;
        item_if.atom_a = '0;
        item_if.atom_b = '0;
        i_rst_n        = 1'b0;
        sb             = new();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // First idling setting: the receiver stalls more than the sender.
        src_idle_pct  = 26;
        sink_idle_pct = 63;

        // Directed beats, most of them on the extreme indexes 0 and 63.
        send_item(ACT_QUERY, 6'd0, 6'd1);     // empty table: unrelated
        send_item(ACT_QUERY, 6'd63, 6'd63);   // same atom twice
        send_item(ACT_BOND, 6'd0, 6'd63);
        send_item(ACT_QUERY, 6'd0, 6'd63);    // bonded
        send_item(ACT_QUERY, 6'd63, 6'd0);    // bonded, pair swapped
        send_item(ACT_BOND, 6'd7, 6'd7);      // self bond changes nothing
        send_item(ACT_QUERY, 6'd7, 6'd7);
        send_item(ACT_QUERY, 6'd7, 6'd0);
        send_item(ACT_BOND, 6'd63, 6'd1);
        send_item(ACT_QUERY, 6'd0, 6'd1);     // shared neighbor 63
        send_item(ACT_QUERY, 6'd1, 6'd0);
        send_item(ACT_BOND, 6'd1, 6'd0);      // closes a ring of three
        send_item(ACT_QUERY, 6'd0, 6'd1);     // direct bond wins
        send_item(ACT_QUERY, 6'd63, 6'd1);
        send_item(ACT_UNUSED, 6'd0, 6'd63);   // must be ignored
        send_item(ACT_UNUSED, 6'd63, 6'd0);
        send_item(ACT_QUERY, 6'd0, 6'd63);
        send_item(ACT_QUERY, 6'd62, 6'd1);
        send_item(ACT_CLEAR, 6'd63, 6'd63);
        send_item(ACT_QUERY, 6'd0, 6'd63);    // gone after the clear
        send_item(ACT_QUERY, 6'd0, 6'd1);
        send_item(ACT_BOND, 6'd63, 6'd62);
        send_item(ACT_QUERY, 6'd62, 6'd63);
        drain_results();

        // Long output stall while the sender keeps going: the output register
        // fills, the next query waits, and the input channel backs up.
        src_idle_pct = 0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
        join_none
        send_item(ACT_BOND, 6'd2, 6'd3);
        send_item(ACT_BOND, 6'd3, 6'd4);
        send_item(ACT_BOND, 6'd4, 6'd5);
        repeat (24)
            send_item(ACT_QUERY, ATOM_W'($urandom_range(7, 0)),
                      ATOM_W'($urandom_range(7, 0)));
        // The sender now waits for every outstanding answer before going on.
        drain_results();

        src_idle_pct = 26;
        while (items_sent < ITEM_TARGET / 3) send_molecule();
        drain_results();

        // Second setting: the sender is the slow side.
        src_idle_pct  = 63;
        sink_idle_pct = 26;
        while (items_sent < 2 * ITEM_TARGET / 3) send_molecule();
        drain_results();

        // Last setting: back-to-back beats on both sides.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (items_sent < ITEM_TARGET) send_molecule();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        failures = sb.finish_check();
        $display("Summary: %0d beats in (%0d clears, %0d bond adds, %0d queries, %0d unused).",
                 sb.beats, sb.clears, sb.bonds, sb.queries, sb.unused);
        $display("Relations expected: %0d bonded, %0d shared neighbor, %0d unrelated; %0d errors.",
                 sb.rel_count[REL_BONDED], sb.rel_count[REL_SHARED],
                 sb.rel_count[REL_NONE], failures);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
